[sv/dtsb_pkg.sv]
// Shared types and constants of the depth-tested sprite blitter.
package dtsb_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ADDR_MAX_W  = 16;
  localparam int RAM_W       = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_MODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT   = 3'd7;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  hit;
    logic                  visible;
    logic [ADDR_MAX_W-1:0] addr;
    logic [15:0]           height;
    logic [31:0]           colour;
  } item_t;

endpackage

[sv/dtsb_if.sv]
// Valid/ready channel interfaces for requests and results.
interface dtsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  col;
  logic [7:0]  row;
  logic [31:0] colour;

  modport source (output valid, output kind, output col, output row, output colour,
                  input ready);
  modport sink (input valid, input kind, input col, input row, input colour,
                output ready);
endinterface

interface dtsb_out_if;
  logic        valid;
  logic        ready;
  logic        wrote;
  logic [31:0] pixel_out;
  logic [15:0] depth_out;

  modport source (output valid, output wrote, output pixel_out, output depth_out,
                  input ready);
  modport sink (input valid, input wrote, input pixel_out, input depth_out,
                output ready);
endinterface

[sv/depth_tested_sprite_blit.sv]
// Top level of the depth-tested sprite blitter.
// Requests arrive on in_ch (valid/ready): kind selects draw, read or clear,
// col and row give the source position (draw) or the buffer position (read
// and clear), and colour carries the ARGB source pixel for draws.
// Every request produces exactly one transaction on out_ch, in request order:
// wrote flags a draw that passed the depth and alpha tests, and pixel_out and
// depth_out return the stored values for reads.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. One request is taken per cycle while in_ch.ready is
// high; a result leaves once its request has passed the decode register, the
// queue, the registered read of the buffer memory and the result register.
// Back-to-back draws to the same pixel are handled by forwarding the last write.
// After reset a clearing pass zeroes the colour and height buffers, one entry
// per cycle, covering all DEST_WIDTH * DEST_HEIGHT entries (4096 by default);
// in_ch.ready stays low until it has finished.
// When out_ch stalls the back end holds, the four-entry queue fills, and
// in_ch.ready drops once the queue and the decode register are full.
module depth_tested_sprite_blit #(
  parameter int DEST_WIDTH  = 64,
  parameter int DEST_HEIGHT = 64,
  parameter int ALPHA_LSB   = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dtsb_in_if.sink                         in_ch,
  dtsb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dtsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtsb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtsb_pkg::*;

  item_t f_item;
  logic  f_valid;
  logic  f_ready;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  clear_done;

  dtsb_front #(
    .DEST_WIDTH  (DEST_WIDTH),
    .DEST_HEIGHT (DEST_HEIGHT),
    .ALPHA_LSB   (ALPHA_LSB)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clear_done (clear_done),
    .f_item     (f_item),
    .f_valid    (f_valid),
    .f_ready    (f_ready)
  );

  dtsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  dtsb_back #(
    .DEST_WIDTH  (DEST_WIDTH),
    .DEST_HEIGHT (DEST_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .clear_done (clear_done),
    .out_ch     (out_ch)
  );

endmodule

[sv/dtsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtsb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dtsb_front.sv]
// Front end: configuration registers, request decode, address and height computation.
module dtsb_front #(
  parameter int DEST_WIDTH  = 64,
  parameter int DEST_HEIGHT = 64,
  parameter int ALPHA_LSB   = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  dtsb_in_if.sink                   in_ch,
  input  logic                      cfg_we,
  input  logic [dtsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                      clear_done,
  output dtsb_pkg::item_t           f_item,
  output logic                      f_valid,
  input  logic                      f_ready
);
  import dtsb_pkg::*;

  logic signed [10:0] dest_x_r;
  logic signed [10:0] dest_y_r;
  logic [8:0]         rect_width_r;
  logic [8:0]         rect_height_r;
  logic [7:0]         rect_top_r;
  logic               mirror_r;
  logic               vertical_mode_r;
  logic [15:0]        base_height_r;

  logic               f_valid_r;
  item_t              f_item_r;
  item_t              item_nxt;
  logic               advance;
  logic               accept;
  op_t                op;
  logic signed [9:0]  c_mir;
  logic signed [9:0]  c_pos;
  logic signed [12:0] x_pos;
  logic signed [11:0] y_pos;
  logic               draw_hit;
  logic               direct_hit;
  logic [15:0]        draw_addr;
  logic [15:0]        direct_addr;
  logic [15:0]        height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      rect_width_r    <= 9'd1;
      rect_height_r   <= 9'd1;
      rect_top_r      <= '0;
      mirror_r        <= 1'b0;
      vertical_mode_r <= 1'b0;
      base_height_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST_X:        dest_x_r        <= $signed(cfg_data[10:0]);
        CFG_DEST_Y:        dest_y_r        <= $signed(cfg_data[10:0]);
        CFG_RECT_WIDTH:    rect_width_r    <= cfg_data[8:0];
        CFG_RECT_HEIGHT:   rect_height_r   <= cfg_data[8:0];
        CFG_RECT_TOP:      rect_top_r      <= cfg_data[7:0];
        CFG_MIRROR:        mirror_r        <= cfg_data[0];
        CFG_VERTICAL_MODE: vertical_mode_r <= cfg_data[0];
        CFG_BASE_HEIGHT:   base_height_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance     = !f_valid_r || f_ready;
  assign in_ch.ready = clear_done && advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    op    = op_t'(in_ch.kind);
    c_mir = $signed({1'b0, rect_width_r}) - 10'sd1 - $signed({2'b00, in_ch.col});
    c_pos = mirror_r ? c_mir : $signed({2'b00, in_ch.col});
    x_pos = 13'(dest_x_r) + 13'(c_pos);
    y_pos = 12'(dest_y_r) + $signed({4'b0000, in_ch.row});

    draw_hit = !x_pos[12] && !y_pos[11] &&
               ($unsigned(x_pos) < 13'(DEST_WIDTH)) &&
               ($unsigned(y_pos) < 12'(DEST_HEIGHT));
    draw_addr = 16'(y_pos[7:0]) * 16'(DEST_WIDTH) + 16'(x_pos[7:0]);

    direct_hit  = ({1'b0, in_ch.col} < 9'(DEST_WIDTH)) &&
                  ({1'b0, in_ch.row} < 9'(DEST_HEIGHT));
    direct_addr = 16'(in_ch.row) * 16'(DEST_WIDTH) + 16'(in_ch.col);

    if (vertical_mode_r) begin
      height = 16'(rect_height_r) - 16'(rect_top_r) - 16'(in_ch.row) +
               base_height_r - 16'd1;
    end else begin
      height = base_height_r;
    end

    item_nxt.op      = op;
    item_nxt.visible = (in_ch.colour[ALPHA_LSB +: 8] != 8'd0);
    item_nxt.height  = height;
    item_nxt.colour  = in_ch.colour;
    if (op == OP_DRAW) begin
      item_nxt.hit  = draw_hit;
      item_nxt.addr = draw_addr;
    end else begin
      item_nxt.hit  = direct_hit;
      item_nxt.addr = direct_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (advance) begin
      f_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_item_r <= item_nxt;
    end
  end

  assign f_item  = f_item_r;
  assign f_valid = f_valid_r;

endmodule

[sv/dtsb_queue.sv]
// Short FIFO that decouples the decode front end from the buffer back end.
module dtsb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsb_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output dtsb_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop
);
  import dtsb_pkg::*;

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/dtsb_back.sv]
// Back end: clearing pass, depth-tested read-modify-write of the buffers, result register.
module dtsb_back #(
  parameter int DEST_WIDTH  = 64,
  parameter int DEST_HEIGHT = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsb_pkg::item_t q_item,
  input  logic            q_valid,
  output logic            q_pop,
  output logic            clear_done,
  dtsb_out_if.source      out_ch
);
  import dtsb_pkg::*;

  localparam int NPIX = DEST_WIDTH * DEST_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);

  logic              clear_done_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              byp_valid_r;
  logic [AW-1:0]     byp_addr_r;
  logic [RAM_W-1:0]  byp_data_r;
  logic              out_valid_r;
  logic              wrote_r;
  logic [31:0]       pixel_r;
  logic [15:0]       depth_r;

  logic              advance;
  logic [RAM_W-1:0]  rd_data;
  logic [RAM_W-1:0]  cur_data;
  logic [31:0]       cur_colour;
  logic [15:0]       cur_depth;
  logic [AW-1:0]     s1_addr;
  logic              draw_wr;
  logic              item_we;
  logic [RAM_W-1:0]  item_wdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;

  assign advance    = !out_valid_r || out_ch.ready;
  assign q_pop      = advance && q_valid && clear_done_r;
  assign clear_done = clear_done_r;
  assign s1_addr    = s1_item_r.addr[AW-1:0];

  always_comb begin
    if (byp_valid_r && (byp_addr_r == s1_addr)) begin
      cur_data = byp_data_r;
    end else begin
      cur_data = rd_data;
    end
    cur_colour = cur_data[RAM_W-1 -: 32];
    cur_depth  = cur_data[15:0];

    draw_wr = (s1_item_r.op == OP_DRAW) && s1_item_r.hit && s1_item_r.visible &&
              (s1_item_r.height > cur_depth);
    item_we = s1_valid_r && advance &&
              (draw_wr || ((s1_item_r.op == OP_CLEAR) && s1_item_r.hit));
    if (s1_item_r.op == OP_DRAW) begin
      item_wdata = {s1_item_r.colour, s1_item_r.height};
    end else begin
      item_wdata = '0;
    end

    if (!clear_done_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = item_we;
      ram_waddr = s1_addr;
      ram_wdata = item_wdata;
    end
  end

  dtsb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NPIX),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_item.addr[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_done_r <= 1'b0;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      byp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!clear_done_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          clear_done_r <= 1'b1;
        end
      end
      if (advance) begin
        s1_valid_r  <= q_pop;
        byp_valid_r <= item_we;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r  <= q_item;
      byp_addr_r <= s1_addr;
      byp_data_r <= item_wdata;
      wrote_r    <= draw_wr;
      if ((s1_item_r.op == OP_READ) && s1_item_r.hit) begin
        pixel_r <= cur_colour;
        depth_r <= cur_depth;
      end else begin
        pixel_r <= '0;
        depth_r <= '0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.wrote     = wrote_r;
  assign out_ch.pixel_out = pixel_r;
  assign out_ch.depth_out = depth_r;

endmodule
